// ===== rtl/lclm_pkg.sv =====
// Shared types, codes and constants of the load-change and level monitor.
// No dependencies; every other file of the block refers to this package.
`default_nettype none
package lclm_pkg;

	// Width of the ADC reading that the block actually uses.
	localparam int unsigned SAMPLE_BITS = 16;

	localparam int unsigned CAL_W   = 16;
	localparam int unsigned DAMP_W  = 8;
	localparam int unsigned THR_W   = 8;
	localparam int unsigned PCT_W   = 8;
	localparam int unsigned TICK_W  = 11;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 16;

	// Magnitude of (sample - null) * 100 fits in this many bits.
	localparam int unsigned MAG_W  = CAL_W + 7;
	// Quotient bits that are produced bit by bit; anything at or above 2**QBITS saturates.
	localparam int unsigned QBITS  = PCT_W + 1;
	localparam int unsigned HI_W   = MAG_W - QBITS;
	localparam int unsigned CNT_W  = $clog2(QBITS);

	localparam logic [TICK_W-1:0] TICK_MAX       = {TICK_W{1'b1}};
	localparam logic [TICK_W-1:0] TICKS_PER_UNIT = TICK_W'(5);
	localparam logic [6:0]        PERCENT_SCALE  = 7'd100;
	localparam logic [PCT_W-1:0]  PCT_SAT        = {PCT_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_NULL_CAL   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_FULL_CAL   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_DAMPING    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_CHANGE_THR = 3'd3;
	localparam logic [CIDX_W-1:0] REG_EMPTY_LVL  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_HEAVY_LVL  = 3'd5;
	localparam logic [CIDX_W-1:0] REG_OVER_LVL   = 3'd6;

	// Item kinds.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Trend codes.
	localparam logic [1:0] TREND_STEADY = 2'd0;
	localparam logic [1:0] TREND_DROP   = 2'd1;
	localparam logic [1:0] TREND_RISE   = 2'd2;

	// Level codes.
	localparam logic [1:0] LEVEL_EMPTY = 2'd0;
	localparam logic [1:0] LEVEL_NORM  = 2'd1;
	localparam logic [1:0] LEVEL_HEAVY = 2'd2;
	localparam logic [1:0] LEVEL_OVER  = 2'd3;

	typedef enum logic [3:0] {
		MON_IDLE = 4'b0001,
		MON_CALC = 4'b0010,
		MON_EVAL = 4'b0100,
		MON_OUT  = 4'b1000
	} mon_state_t;

	typedef enum logic [3:0] {
		PCT_IDLE  = 4'b0001,
		PCT_PREP  = 4'b0010,
		PCT_CHECK = 4'b0100,
		PCT_DIV   = 4'b1000
	} pct_state_t;

	// Result of the percentage unit: done pulses for one cycle with pct valid.
	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] pct;
	} pct_res_t;

endpackage
`default_nettype wire

// ===== rtl/lclm_if.sv =====
// Handshake channels of the load-change and level monitor: request and response.
// Depends on lclm_pkg for the field widths.
`default_nettype none
interface lclm_req_if;
	logic                              valid;
	logic                              ready;
	logic                              func;
	logic [15:0]                       sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink (input valid, input func, input sample, output ready);
endinterface

interface lclm_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        trend;
	logic [1:0]                        level;
	logic [lclm_pkg::PCT_W-1:0]        percent_now;

	modport source (output valid, output trend, output level, output percent_now, input ready);
	modport sink (input valid, input trend, input level, input percent_now, output ready);
endinterface
`default_nettype wire

// ===== rtl/lclm_pct_unit.sv =====
// Percentage unit: trunc((sample - null) * 100 / (full - null)), clamped to 0..255.
// One shared subtractor runs a restoring division one quotient bit per cycle. Uses lclm_pkg.
`default_nettype none
module lclm_pct_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire  [lclm_pkg::SAMPLE_BITS-1:0]   sample,
	input  wire  [lclm_pkg::CAL_W-1:0]         null_cal,
	input  wire  [lclm_pkg::CAL_W-1:0]         full_cal,
	output lclm_pkg::pct_res_t                 res
);

	lclm_pkg::pct_state_t              state_q;
	logic [lclm_pkg::MAG_W-1:0]        mag_q;
	logic [lclm_pkg::CAL_W-1:0]        den_q;
	logic [lclm_pkg::CAL_W-1:0]        rem_q;
	logic [lclm_pkg::QBITS-1:0]        lo_q;
	logic [lclm_pkg::PCT_W-1:0]        quo_q;
	logic [lclm_pkg::CNT_W-1:0]        cnt_q;
	lclm_pkg::pct_res_t                res_q;

	logic signed [lclm_pkg::CAL_W:0]   num_d;
	logic signed [lclm_pkg::CAL_W:0]   den_d;
	logic        [lclm_pkg::CAL_W:0]   num_abs;
	logic        [lclm_pkg::CAL_W:0]   den_abs;
	logic                              zero_res;
	logic        [lclm_pkg::CAL_W:0]   opa;
	logic        [lclm_pkg::CAL_W+1:0] diff;
	logic                              fits;
	logic        [lclm_pkg::QBITS-1:0] quo_next;

	// Signed span terms and their magnitudes.
	always_comb begin
		num_d   = $signed({1'b0, lclm_pkg::CAL_W'(sample)}) - $signed({1'b0, null_cal});
		den_d   = $signed({1'b0, full_cal}) - $signed({1'b0, null_cal});
		num_abs = num_d[lclm_pkg::CAL_W] ? (lclm_pkg::CAL_W+1)'(-num_d) : num_d;
		den_abs = den_d[lclm_pkg::CAL_W] ? (lclm_pkg::CAL_W+1)'(-den_d) : den_d;
		// A zero span, or a quotient that comes out negative, gives zero.
		zero_res = (den_d == '0) || (num_d[lclm_pkg::CAL_W] != den_d[lclm_pkg::CAL_W]);
	end

	// The shared subtractor: partial remainder against the span magnitude.
	always_comb begin
		if (state_q == lclm_pkg::PCT_CHECK) begin
			opa = (lclm_pkg::CAL_W+1)'(mag_q[lclm_pkg::MAG_W-1:lclm_pkg::QBITS]);
		end else begin
			opa = {rem_q, lo_q[lclm_pkg::QBITS-1]};
		end
		diff     = {1'b0, opa} - {2'b00, den_q};
		fits     = !diff[lclm_pkg::CAL_W+1];
		quo_next = {quo_q, fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lclm_pkg::PCT_IDLE;
			res_q   <= '0;
		end else begin
			res_q.done <= 1'b0;
			case (state_q)
				lclm_pkg::PCT_IDLE: begin
					if (start) begin
						state_q <= lclm_pkg::PCT_PREP;
					end
				end
				lclm_pkg::PCT_PREP: begin
					if (zero_res) begin
						res_q.done <= 1'b1;
						res_q.pct  <= '0;
						state_q    <= lclm_pkg::PCT_IDLE;
					end else begin
						state_q <= lclm_pkg::PCT_CHECK;
					end
				end
				lclm_pkg::PCT_CHECK: begin
					// If the top bits alone reach the span, the quotient is far above 255.
					if (fits) begin
						res_q.done <= 1'b1;
						res_q.pct  <= lclm_pkg::PCT_SAT;
						state_q    <= lclm_pkg::PCT_IDLE;
					end else begin
						state_q <= lclm_pkg::PCT_DIV;
					end
				end
				lclm_pkg::PCT_DIV: begin
					if (cnt_q == lclm_pkg::CNT_W'(lclm_pkg::QBITS - 1)) begin
						res_q.done <= 1'b1;
						res_q.pct  <= quo_next[lclm_pkg::QBITS-1] ? lclm_pkg::PCT_SAT
						                                         : quo_next[lclm_pkg::PCT_W-1:0];
						state_q    <= lclm_pkg::PCT_IDLE;
					end
				end
				default: begin
					state_q <= lclm_pkg::PCT_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			lclm_pkg::PCT_PREP: begin
				mag_q <= lclm_pkg::MAG_W'(num_abs[lclm_pkg::CAL_W-1:0])
				         * lclm_pkg::MAG_W'(lclm_pkg::PERCENT_SCALE);
				den_q <= den_abs[lclm_pkg::CAL_W-1:0];
			end
			lclm_pkg::PCT_CHECK: begin
				rem_q <= lclm_pkg::CAL_W'(mag_q[lclm_pkg::MAG_W-1:lclm_pkg::QBITS]);
				lo_q  <= mag_q[lclm_pkg::QBITS-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			lclm_pkg::PCT_DIV: begin
				if (fits) begin
					rem_q <= diff[lclm_pkg::CAL_W-1:0];
				end else begin
					rem_q <= opa[lclm_pkg::CAL_W-1:0];
				end
				lo_q  <= {lo_q[lclm_pkg::QBITS-2:0], 1'b0};
				quo_q <= quo_next[lclm_pkg::PCT_W-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule
`default_nettype wire

// ===== rtl/load_change_and_level_monitor.sv =====
// Top level of the load-change and level monitor: configuration registers, item sequencer,
// trend logic and output register. Depends on lclm_pkg, lclm_if and lclm_pct_unit.
`default_nettype none
// The block watches a load-sensor ADC stream that arrives as items on the req channel. A tick
// item (func = 1) advances a damping counter that saturates at 2047; it is taken in the idle
// state and produces no response. A sample item (func = 0) always produces exactly one response
// item on the rsp channel with its load level from the three threshold registers. When the
// counter has reached damping * 5, the sample is also evaluated: the counter clears, the sample
// is turned into a percentage of the calibrated span, truncated and clamped to 0..255, and the
// change against the previous percentage updates the held trend flag. A sample that is not
// evaluated goes to the output state, which loads a registered response once the output
// register has room. An evaluated sample waits for the percentage unit, whose one subtractor
// produces one quotient bit per cycle over nine steps after an operand preparation step and a
// range-check step. A zero span or a negative quotient finishes after preparation. The block
// takes no new item while a sample is in work. The response sits in an output register, so the
// next tick or sample can be accepted while an earlier response waits to be taken. Configuration
// is to be written through cfg_we, cfg_idx and cfg_data only while the block is idle; the block
// itself does not enforce this. Indexes beyond the register list are ignored.
module load_change_and_level_monitor (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [lclm_pkg::CIDX_W-1:0]       cfg_idx,
	input  wire  [lclm_pkg::CDATA_W-1:0]      cfg_data,
	lclm_req_if.sink                          req,
	lclm_rsp_if.source                        rsp
);

	// Configuration registers.
	logic [lclm_pkg::CAL_W-1:0]       null_cal_q;
	logic [lclm_pkg::CAL_W-1:0]       full_cal_q;
	logic [lclm_pkg::DAMP_W-1:0]      damping_q;
	logic [lclm_pkg::THR_W-1:0]       change_thr_q;
	logic [lclm_pkg::CAL_W-1:0]       empty_lvl_q;
	logic [lclm_pkg::CAL_W-1:0]       heavy_lvl_q;
	logic [lclm_pkg::CAL_W-1:0]       over_lvl_q;

	// Monitor state.
	lclm_pkg::mon_state_t             state_q;
	logic [lclm_pkg::TICK_W-1:0]      tick_count_q;
	logic [lclm_pkg::PCT_W-1:0]       prev_pct_q;
	logic [1:0]                       trend_q;
	logic [lclm_pkg::PCT_W-1:0]       pct_q;
	logic [lclm_pkg::SAMPLE_BITS-1:0] sample_q;
	logic [1:0]                       level_q;

	// Output register.
	logic                             rsp_valid_q;
	logic [1:0]                       rsp_trend_q;
	logic [1:0]                       rsp_level_q;
	logic [lclm_pkg::PCT_W-1:0]       rsp_pct_q;

	logic                             accept;
	logic [lclm_pkg::SAMPLE_BITS-1:0] sample_in;
	logic [lclm_pkg::CAL_W-1:0]       sample_ext;
	logic [1:0]                       level_in;
	logic [lclm_pkg::TICK_W-1:0]      eval_ticks;
	logic                             eval_due;
	logic                             start;
	logic                             out_free;
	logic                             rise;
	logic [lclm_pkg::PCT_W-1:0]       delta;
	lclm_pkg::pct_res_t               pct_res;

	assign req.ready = (state_q == lclm_pkg::MON_IDLE);
	assign accept    = req.valid && req.ready;

	// Only the low SAMPLE_BITS bits of the reading take part.
	assign sample_in  = req.sample[lclm_pkg::SAMPLE_BITS-1:0];
	assign sample_ext = lclm_pkg::CAL_W'(sample_in);

	always_comb begin
		if (sample_ext <= empty_lvl_q) begin
			level_in = lclm_pkg::LEVEL_EMPTY;
		end else if (sample_ext < heavy_lvl_q) begin
			level_in = lclm_pkg::LEVEL_NORM;
		end else if (sample_ext < over_lvl_q) begin
			level_in = lclm_pkg::LEVEL_HEAVY;
		end else begin
			level_in = lclm_pkg::LEVEL_OVER;
		end
	end

	assign eval_ticks = lclm_pkg::TICK_W'(damping_q) * lclm_pkg::TICKS_PER_UNIT;
	assign eval_due   = (tick_count_q >= eval_ticks);
	assign start      = accept && (req.func == lclm_pkg::FUNC_SAMPLE) && eval_due;

	// The response register can load when it is empty or being taken in this cycle.
	assign out_free = !rsp_valid_q || rsp.ready;

	// Trend comparison of the new percentage against the previous one.
	always_comb begin
		rise  = (pct_q > prev_pct_q);
		delta = rise ? (pct_q - prev_pct_q) : (prev_pct_q - pct_q);
	end

	lclm_pct_unit u_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sample   (sample_q),
		.null_cal (null_cal_q),
		.full_cal (full_cal_q),
		.res      (pct_res)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_cal_q   <= lclm_pkg::CAL_W'(0);
			full_cal_q   <= lclm_pkg::CAL_W'(4095);
			damping_q    <= lclm_pkg::DAMP_W'(1);
			change_thr_q <= lclm_pkg::THR_W'(10);
			empty_lvl_q  <= lclm_pkg::CAL_W'(100);
			heavy_lvl_q  <= lclm_pkg::CAL_W'(3500);
			over_lvl_q   <= lclm_pkg::CAL_W'(4000);
		end else if (cfg_we) begin
			case (cfg_idx)
				lclm_pkg::REG_NULL_CAL:   null_cal_q   <= cfg_data[lclm_pkg::CAL_W-1:0];
				lclm_pkg::REG_FULL_CAL:   full_cal_q   <= cfg_data[lclm_pkg::CAL_W-1:0];
				lclm_pkg::REG_DAMPING:    damping_q    <= cfg_data[lclm_pkg::DAMP_W-1:0];
				lclm_pkg::REG_CHANGE_THR: change_thr_q <= cfg_data[lclm_pkg::THR_W-1:0];
				lclm_pkg::REG_EMPTY_LVL:  empty_lvl_q  <= cfg_data[lclm_pkg::CAL_W-1:0];
				lclm_pkg::REG_HEAVY_LVL:  heavy_lvl_q  <= cfg_data[lclm_pkg::CAL_W-1:0];
				lclm_pkg::REG_OVER_LVL:   over_lvl_q   <= cfg_data[lclm_pkg::CAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Item sequencer and monitor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lclm_pkg::MON_IDLE;
			tick_count_q <= '0;
			prev_pct_q   <= '0;
			trend_q      <= lclm_pkg::TREND_STEADY;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				lclm_pkg::MON_IDLE: begin
					if (accept) begin
						if (req.func == lclm_pkg::FUNC_TICK) begin
							if (tick_count_q != lclm_pkg::TICK_MAX) begin
								tick_count_q <= tick_count_q + 1'b1;
							end
						end else if (eval_due) begin
							tick_count_q <= '0;
							state_q      <= lclm_pkg::MON_CALC;
						end else begin
							state_q <= lclm_pkg::MON_OUT;
						end
					end
				end
				lclm_pkg::MON_CALC: begin
					if (pct_res.done) begin
						state_q <= lclm_pkg::MON_EVAL;
					end
				end
				lclm_pkg::MON_EVAL: begin
					if (rise) begin
						trend_q <= (delta >= change_thr_q) ? lclm_pkg::TREND_RISE
						                                   : lclm_pkg::TREND_STEADY;
					end else begin
						trend_q <= (delta >= change_thr_q) ? lclm_pkg::TREND_DROP
						                                   : lclm_pkg::TREND_STEADY;
					end
					prev_pct_q <= pct_q;
					state_q    <= lclm_pkg::MON_OUT;
				end
				lclm_pkg::MON_OUT: begin
					// Wait here until the response register has room.
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= lclm_pkg::MON_IDLE;
					end
				end
				default: begin
					state_q <= lclm_pkg::MON_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept && (req.func == lclm_pkg::FUNC_SAMPLE)) begin
			sample_q <= sample_in;
			level_q  <= level_in;
		end
		if (pct_res.done) begin
			pct_q <= pct_res.pct;
		end
		if ((state_q == lclm_pkg::MON_OUT) && out_free) begin
			rsp_trend_q <= trend_q;
			rsp_level_q <= level_q;
			rsp_pct_q   <= prev_pct_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.trend       = rsp_trend_q;
	assign rsp.level       = rsp_level_q;
	assign rsp.percent_now = rsp_pct_q;

endmodule
`default_nettype wire

// ===== tb/tb_load_change_and_level_monitor.sv =====
// Self-checking testbench of the load-change and level monitor: directed and random item
// streams, a scoreboard class that predicts every response item, and random idling on both sides.
// Depends on lclm_pkg, the lclm_req_if and lclm_rsp_if interfaces, and the monitor itself.
import lclm_pkg::*;

// One response item as the block reports it.
typedef struct packed {
	logic [1:0]       trend;
	logic [1:0]       level;
	logic [PCT_W-1:0] percent;
} load_report_t;

// Holds a copy of the configuration registers and of the monitor state. Every accepted request
// item advances that copy; every sample item adds one expected report to the queue.
class lclm_scoreboard;
	logic [CAL_W-1:0]  null_cal;
	logic [CAL_W-1:0]  full_cal;
	logic [DAMP_W-1:0] damping;
	logic [THR_W-1:0]  change_thr;
	logic [CAL_W-1:0]  empty_lvl;
	logic [CAL_W-1:0]  heavy_lvl;
	logic [CAL_W-1:0]  over_lvl;
	logic [TICK_W-1:0] tick_count;
	logic [PCT_W-1:0]  last_pct;
	logic [1:0]        trend_flag;
	load_report_t      pending_reports[$];
	int                error_count;

	function new();
		reset_state();
	endfunction

	function void reset_state();
		null_cal   = 16'd0;
		full_cal   = 16'd4095;
		damping    = 8'd1;
		change_thr = 8'd10;
		empty_lvl  = 16'd100;
		heavy_lvl  = 16'd3500;
		over_lvl   = 16'd4000;
		tick_count = '0;
		last_pct   = '0;
		trend_flag = TREND_STEADY;
		pending_reports.delete();
		error_count = 0;
	endfunction

	function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		case (idx)
		REG_NULL_CAL:   null_cal   = data;
		REG_FULL_CAL:   full_cal   = data;
		REG_DAMPING:    damping    = data[DAMP_W-1:0];
		REG_CHANGE_THR: change_thr = data[THR_W-1:0];
		REG_EMPTY_LVL:  empty_lvl  = data;
		REG_HEAVY_LVL:  heavy_lvl  = data;
		REG_OVER_LVL:   over_lvl   = data;
		default: ;
		endcase
	endfunction

	// Signed percentage of the calibrated span, truncated toward zero and clamped to 0..255.
	function logic [PCT_W-1:0] load_percent(logic [SAMPLE_BITS-1:0] s);
		longint sv;
		longint nv;
		longint fv;
		longint scale;
		longint quo;
		sv = s;
		nv = null_cal;
		fv = full_cal;
		scale = PERCENT_SCALE;
		if (fv == nv)
			return '0;
		quo = ((sv - nv) * scale) / (fv - nv);
		if (quo < 0)
			return '0;
		if (quo > PCT_SAT)
			return PCT_SAT;
		return quo[PCT_W-1:0];
	endfunction

	function logic [1:0] load_level(logic [SAMPLE_BITS-1:0] s);
		if (s <= empty_lvl)
			return LEVEL_EMPTY;
		if (s < heavy_lvl)
			return LEVEL_NORM;
		if (s < over_lvl)
			return LEVEL_HEAVY;
		return LEVEL_OVER;
	endfunction

	function void note_item(logic func, logic [SAMPLE_BITS-1:0] s);
		logic [PCT_W-1:0] pct;
		load_report_t     rep;
		if (func == FUNC_TICK) begin
			if (tick_count != TICK_MAX)
				tick_count = tick_count + 1'b1;
			return;
		end
		if (tick_count >= damping * TICKS_PER_UNIT) begin
			pct = load_percent(s);
			tick_count = '0;
			if (pct > last_pct)
				trend_flag = (pct - last_pct >= change_thr) ? TREND_RISE : TREND_STEADY;
			else
				trend_flag = (last_pct - pct >= change_thr) ? TREND_DROP : TREND_STEADY;
			last_pct = pct;
		end
		rep.trend   = trend_flag;
		rep.level   = load_level(s);
		rep.percent = last_pct;
		pending_reports.push_back(rep);
	endfunction

	function void check_result(logic [1:0] trend, logic [1:0] level, logic [PCT_W-1:0] pct);
		load_report_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t: response item with none expected: trend %0d level %0d percent %0d",
				$time, trend, level, pct);
			error_count++;
			return;
		end
		want = pending_reports.pop_front();
		if (trend !== want.trend) begin
			$display("%0t: trend mismatch, expected %0d, actual %0d", $time, want.trend, trend);
			error_count++;
		end
		if (level !== want.level) begin
			$display("%0t: level mismatch, expected %0d, actual %0d", $time, want.level, level);
			error_count++;
		end
		if (pct !== want.percent) begin
			$display("%0t: percent_now mismatch, expected %0d, actual %0d",
				$time, want.percent, pct);
			error_count++;
		end
	endfunction

	function int pending();
		return pending_reports.size();
	endfunction
endclass

module tb_load_change_and_level_monitor;
	// Pause before any register write and before the final verdict; it covers an evaluated sample
	// in the block with margin.
	localparam int SETTLE_CYCLES = 20;
	// Length of the long receiver stall that fills the output register and the sequencer.
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_SETUP = 64;
	// The limit lies well above the slowest correct run: some 650 items in all, with either side
	// idle almost half the time, thirteen settle pauses and one long stall.
	localparam int LIMIT_CYCLES = 400000;
	// Index just past the register list; writes to it must change nothing.
	localparam logic [CIDX_W-1:0] REG_UNUSED = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_idx;
	logic [CDATA_W-1:0]  cfg_data;
	int                  tx_idle_pct = 6;
	int                  rx_idle_pct = 46;
	logic                hold_request = 1'b0;
	int                  cycle_count = 0;
	lclm_scoreboard      sb;

	lclm_req_if req_ch();
	lclm_rsp_if rsp_ch();

	load_change_and_level_monitor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("load_change_and_level_monitor verification failed");
			$finish;
		end
	end

	// Both channels are sampled at the clock edge, before any of this edge's updates land. The
	// response is checked first so that an item accepted at the same edge cannot stand in for a
	// response that nobody was waiting for.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.trend, rsp_ch.level, rsp_ch.percent_now);
			if (req_ch.valid && req_ch.ready)
				sb.note_item(req_ch.func, req_ch.sample);
		end
	end

	// Receiver. It drops ready at random at the current idle rate. Once the stimulus raises
	// hold_request it keeps ready low for a long stretch, counted here, while the sender keeps
	// offering items, so that the block backs up and stalls its request channel.
	initial begin
		logic hold_done;
		rsp_ch.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
			end
		end
	end

	// Offers one item and returns at the edge where it is taken. Idle cycles come first, so valid
	// only goes low right after an acceptance and never drops and rises in the same step.
	task automatic send_item(input logic func, input logic [SAMPLE_BITS-1:0] s);
		while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.func   <= func;
		req_ch.sample <= s;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	// Tick items carry a random sample field, which the block must ignore.
	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_item(FUNC_TICK, 16'($urandom));
	endtask

	// Withdraws the last offered item, waits until every expected response has come back, then
	// lets the block settle, since a tick accepted last produces nothing to wait for.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register at the next edge. The write enable stays high; the caller lowers it
	// after the last write of a burst.
	task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Every setting starts with a write to the index past the list, which must be ignored.
	task automatic apply_setup(input logic [15:0] null_val, full_val,
			input logic [7:0] damp_val, thr_val,
			input logic [15:0] empty_val, heavy_val, over_val);
		wait_idle();
		set_reg(REG_UNUSED, 16'($urandom));
		set_reg(REG_NULL_CAL, null_val);
		set_reg(REG_FULL_CAL, full_val);
		set_reg(REG_DAMPING, {8'd0, damp_val});
		set_reg(REG_CHANGE_THR, {8'd0, thr_val});
		set_reg(REG_EMPTY_LVL, empty_val);
		set_reg(REG_HEAVY_LVL, heavy_val);
		set_reg(REG_OVER_LVL, over_val);
		cfg_we <= 1'b0;
	endtask

	// Mostly a normal calibration with ordered levels, short damping and small thresholds;
	// sometimes an inverted or zero span, a large threshold, or levels in no order.
	task automatic random_setup();
		logic [15:0] null_val;
		logic [15:0] full_val;
		logic [15:0] lv[3];
		logic [15:0] swap;
		logic [7:0]  damp_val;
		logic [7:0]  thr_val;
		int          pick;
		null_val = ($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'($urandom_range(1500, 0));
		pick = $urandom_range(19, 0);
		if (pick == 0)
			full_val = null_val;
		else if (pick < 3)
			full_val = 16'($urandom);
		else
			full_val = 16'(null_val + $urandom_range(4000, 1));
		damp_val = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(10, 3))
			: 8'($urandom_range(2, 0));
		thr_val = ($urandom_range(2, 0) == 0) ? 8'($urandom) : 8'($urandom_range(20, 0));
		if ($urandom_range(4, 0) == 0) begin
			foreach (lv[i])
				lv[i] = 16'($urandom);
		end else begin
			foreach (lv[i])
				lv[i] = 16'($urandom_range(6000, 0));
			for (int pass = 0; pass < 2; pass++) begin
				for (int i = 0; i < 2; i++) begin
					if (lv[i] > lv[i + 1]) begin
						swap = lv[i];
						lv[i] = lv[i + 1];
						lv[i + 1] = swap;
					end
				end
			end
		end
		apply_setup(null_val, full_val, damp_val, thr_val, lv[0], lv[1], lv[2]);
	endtask

	// A reading that tends to fall in or near the calibrated span, or right at a level boundary,
	// with a share of fully random readings.
	function automatic logic [SAMPLE_BITS-1:0] span_sample();
		int lo;
		int hi;
		int r;
		logic [15:0] edge_lvl;
		lo = (sb.null_cal < sb.full_cal) ? sb.null_cal : sb.full_cal;
		hi = (sb.null_cal < sb.full_cal) ? sb.full_cal : sb.null_cal;
		r = $urandom_range(9, 0);
		if (r < 6)
			return 16'($urandom_range((hi > 65235) ? 65535 : hi + 300, (lo < 300) ? 0 : lo - 300));
		if (r < 8) begin
			case ($urandom_range(2, 0))
			0: edge_lvl = sb.empty_lvl;
			1: edge_lvl = sb.heavy_lvl;
			default: edge_lvl = sb.over_lvl;
			endcase
			return 16'(edge_lvl + $urandom_range(2, 0) - 1);
		end
		return 16'($urandom);
	endfunction

	// Most of the stream is runs of ticks that bring the counter to the evaluation point, followed
	// by a sample; some runs fall short or overshoot. The rest is lone ticks and random samples.
	task automatic run_random(input int n);
		int sent;
		int r;
		int need;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(99, 0);
			if (r < 70) begin
				need = sb.damping * TICKS_PER_UNIT;
				case ($urandom_range(4, 0))
				0: need = $urandom_range(need, 0);
				1: need = need + $urandom_range(3, 1);
				default: ;
				endcase
				send_ticks(need);
				send_item(FUNC_SAMPLE, span_sample());
				sent += need + 1;
			end else if (r < 82) begin
				send_item(FUNC_TICK, 16'($urandom));
				sent++;
			end else begin
				send_item(FUNC_SAMPLE, 16'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = REG_NULL_CAL;
		cfg_data      = '0;
		req_ch.valid  = 1'b0;
		req_ch.func   = FUNC_SAMPLE;
		req_ch.sample = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: span 0..4095, five ticks per evaluation, threshold 10.
		// A sample before any tick is not evaluated and reports percent 0.
		send_item(FUNC_SAMPLE, 16'd0);
		// Full scale after the interval: 100 percent, a sudden rise.
		send_ticks(5);
		send_item(FUNC_SAMPLE, 16'd4095);
		// Unevaluated samples on both sides of every level boundary.
		send_item(FUNC_SAMPLE, 16'hFFFF);
		send_item(FUNC_SAMPLE, 16'd100);
		send_item(FUNC_SAMPLE, 16'd101);
		send_item(FUNC_SAMPLE, 16'd3499);
		send_item(FUNC_SAMPLE, 16'd3500);
		send_item(FUNC_SAMPLE, 16'd3999);
		send_item(FUNC_SAMPLE, 16'd4000);
		// Same percentage again settles the trend; then a drop; then a reading far above the
		// span, whose percentage saturates.
		send_ticks(5);
		send_item(FUNC_SAMPLE, 16'd4095);
		send_ticks(5);
		send_item(FUNC_SAMPLE, 16'd2000);
		send_ticks(5);
		send_item(FUNC_SAMPLE, 16'hFFFF);

		// Inverted span, zero damping so that every sample is evaluated, zero threshold so that
		// an unchanged percentage counts as a drop, and levels out of order.
		apply_setup(16'd4000, 16'd0, 8'd0, 8'd0, 16'd0, 16'hFFFF, 16'd0);
		send_item(FUNC_SAMPLE, 16'd0);
		send_item(FUNC_SAMPLE, 16'hFFFF);
		send_item(FUNC_SAMPLE, 16'd4000);
		send_item(FUNC_SAMPLE, 16'd2500);

		// Zero span at the top of the range, largest threshold.
		apply_setup(16'hFFFF, 16'hFFFF, 8'd0, 8'hFF, 16'hFFFF, 16'd0, 16'hFFFF);
		send_item(FUNC_SAMPLE, 16'd0);
		send_item(FUNC_SAMPLE, 16'hFFFF);
		send_item(FUNC_SAMPLE, 16'd1234);

		// Damping of four. Ticks past the interval still evaluate the sample; then one tick
		// short of the interval leaves a sample unevaluated, and the tick that completes it
		// evaluates the next one.
		apply_setup(16'd0, 16'hFFFF, 8'd4, 8'd1, 16'd0, 16'hFFFF, 16'hFFFF);
		send_ticks(24);
		send_item(FUNC_SAMPLE, 16'hFFFF);
		send_ticks(19);
		send_item(FUNC_SAMPLE, 16'h8000);
		send_ticks(1);
		send_item(FUNC_SAMPLE, 16'd0);

		// Random part in three idling modes with three settings each. The long receiver stall
		// falls in the last mode, where the sender never pauses.
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 46 : 0;
			rx_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 6 : 0;
			for (int k = 0; k < 3; k++) begin
				random_setup();
				if (mode == 2 && k == 0)
					hold_request = 1'b1;
				run_random(ITEMS_PER_SETUP);
			end
		end

		wait_idle();
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("load_change_and_level_monitor verification clean");
		else
			$display("load_change_and_level_monitor verification failed");
		$finish;
	end
endmodule
